// ===== rtl/core/lss_pkg.sv =====
`timescale 1ns / 1ps

package lss_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 3;
  localparam int unsigned SCRIPT_DEPTH_DEF = 256;
  localparam int unsigned MAX_STEPS_DEF    = 64;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned CHAN_W = 2;
  localparam int unsigned ADDR_W = 8;
  localparam int unsigned LEN_W  = 9;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned OUT_W  = 3;

  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_START = 2'd2;

  localparam logic [BYTE_W-1:0] CMD_NOP     = 8'h00;
  localparam logic [BYTE_W-1:0] CMD_ON      = 8'h01;
  localparam logic [BYTE_W-1:0] CMD_OFF     = 8'h02;
  localparam logic [BYTE_W-1:0] CMD_DELAY   = 8'h03;
  localparam logic [BYTE_W-1:0] CMD_RESTART = 8'h04;
  localparam logic [BYTE_W-1:0] CMD_END     = 8'h05;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [OUT_W-1:0] led_on;
    logic [OUT_W-1:0] channel_idle;
    logic [OUT_W-1:0] script_error;
    logic             start_taken;
  } result_t;

endpackage

// ===== rtl/core/lss_if.sv =====
`timescale 1ns / 1ps

interface lss_in_if;
  logic                        valid;
  logic                        ready;
  logic [lss_pkg::KIND_W-1:0]  kind;
  logic [lss_pkg::CHAN_W-1:0]  channel;
  logic [lss_pkg::ADDR_W-1:0]  address;
  logic [lss_pkg::LEN_W-1:0]   script_length;
  logic [lss_pkg::BYTE_W-1:0]  data_byte;
  logic                        immediate;

  modport source (
    output valid, kind, channel, address, script_length, data_byte, immediate,
    input  ready
  );
  modport sink (
    input  valid, kind, channel, address, script_length, data_byte, immediate,
    output ready
  );
endinterface

interface lss_out_if;
  logic                       valid;
  logic                       ready;
  logic [lss_pkg::OUT_W-1:0]  led_on;
  logic [lss_pkg::OUT_W-1:0]  channel_idle;
  logic [lss_pkg::OUT_W-1:0]  script_error;
  logic                       start_taken;

  modport source (
    output valid, led_on, channel_idle, script_error, start_taken,
    input  ready
  );
  modport sink (
    input  valid, led_on, channel_idle, script_error, start_taken,
    output ready
  );
endinterface

// ===== rtl/core/lss_script_mem.sv =====
`timescale 1ns / 1ps

module lss_script_mem #(
  parameter int unsigned SCRIPT_DEPTH = lss_pkg::SCRIPT_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  lss_pkg::mem_req_t           mem_req_i,
  output logic [lss_pkg::BYTE_W-1:0]  rdata_o
);

  localparam int unsigned AW = $clog2(SCRIPT_DEPTH);

  logic [lss_pkg::BYTE_W-1:0] mem [SCRIPT_DEPTH];
  logic [lss_pkg::BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.we) begin
      mem[mem_req_i.waddr[AW-1:0]] <= mem_req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_req_i.re) begin
      rdata_q <= mem[mem_req_i.raddr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/lss_seq.sv =====
`timescale 1ns / 1ps

module lss_seq #(
  parameter int unsigned NUM_CHANNELS = lss_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned SCRIPT_DEPTH = lss_pkg::SCRIPT_DEPTH_DEF,
  parameter int unsigned MAX_STEPS    = lss_pkg::MAX_STEPS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lss_in_if.sink                      in_i,
  output lss_pkg::mem_req_t           mem_req_o,
  input  logic [lss_pkg::BYTE_W-1:0]  mem_rdata_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output lss_pkg::result_t            res_o
);

  localparam int unsigned AW    = $clog2(SCRIPT_DEPTH);
  localparam int unsigned OW    = $clog2(SCRIPT_DEPTH + 1);
  localparam int unsigned SW    = $clog2(MAX_STEPS + 1);
  localparam int unsigned CW    = $clog2(NUM_CHANNELS + 1);
  localparam int unsigned IW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned RES_W = lss_pkg::OUT_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_TICK   = 3'd2;
  localparam logic [2:0] S_FETCH  = 3'd3;
  localparam logic [2:0] S_EXEC   = 3'd4;
  localparam logic [2:0] S_DELAY  = 3'd5;
  localparam logic [2:0] S_RESULT = 3'd6;

  logic [2:0]                 state_q, state_d;
  logic [lss_pkg::KIND_W-1:0] kind_q;
  logic [lss_pkg::ADDR_W-1:0] acc_q;
  logic [lss_pkg::LEN_W-1:0]  len_q;
  logic [lss_pkg::BYTE_W-1:0] data_q;
  logic [CW-1:0]              cur_ch_q;
  logic                       taken_q;
  logic [NUM_CHANNELS-1:0]    err_q;
  logic [OW-1:0]              w_off_q;
  logic [AW-1:0]              w_addr_q;
  logic [SW-1:0]              steps_q;

  logic [AW-1:0]              base_q  [NUM_CHANNELS];
  logic [OW-1:0]              size_q  [NUM_CHANNELS];
  logic [OW-1:0]              off_q   [NUM_CHANNELS];
  logic [AW-1:0]              raddr_q [NUM_CHANNELS];
  logic [7:0]                 ticks_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]    idle_q;
  logic [NUM_CHANNELS-1:0]    wait_q;
  logic [NUM_CHANNELS-1:0]    lit_q;

  logic [IW-1:0] ci;
  logic [3:0]    chan4;
  logic          start_ok;
  logic          acc_ge;
  logic [AW-1:0] acc_red;
  logic [OW-1:0] len_sat;
  logic [AW-1:0] addr_inc;
  logic          off_end;
  logic          steps_max;
  logic          tick_done;
  logic          chan_skip;
  logic          run_end;
  logic [2:0]    fin_state;

  assign ci        = cur_ch_q[IW-1:0];
  assign chan4     = 4'(in_i.channel);
  assign start_ok  = (in_i.kind == lss_pkg::KIND_START) && (chan4 < 4'(NUM_CHANNELS))
                     && (in_i.immediate || idle_q[chan4[IW-1:0]]);
  assign acc_ge    = 9'(acc_q) >= 9'(SCRIPT_DEPTH);
  assign acc_red   = acc_q[AW-1:0];
  assign len_sat   = (len_q > 9'(SCRIPT_DEPTH)) ? OW'(SCRIPT_DEPTH) : OW'(len_q);
  assign addr_inc  = (w_addr_q == AW'(SCRIPT_DEPTH - 1)) ? '0 : w_addr_q + AW'(1);
  assign off_end   = w_off_q >= size_q[ci];
  assign steps_max = steps_q == SW'(MAX_STEPS);
  assign tick_done = cur_ch_q == CW'(NUM_CHANNELS);
  assign chan_skip = idle_q[ci] || !wait_q[ci] || (ticks_q[ci] > 8'd1);
  assign fin_state = (kind_q == lss_pkg::KIND_TICK) ? S_TICK : S_RESULT;

  // memory port
  always_comb begin
    mem_req_o.we    = (state_q == S_REDUCE) && !acc_ge && (kind_q == lss_pkg::KIND_WRITE);
    mem_req_o.waddr = 8'(acc_red);
    mem_req_o.wdata = data_q;
    mem_req_o.re    = ((state_q == S_FETCH) && !steps_max && !off_end)
                      || ((state_q == S_EXEC) && (mem_rdata_i == lss_pkg::CMD_DELAY)
                          && !off_end);
    mem_req_o.raddr = 8'(w_addr_q);
  end

  always_comb begin
    state_d = state_q;
    run_end = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          unique case (in_i.kind)
            lss_pkg::KIND_TICK:  state_d = S_TICK;
            lss_pkg::KIND_WRITE: state_d = S_REDUCE;
            lss_pkg::KIND_START: state_d = start_ok ? S_REDUCE : S_RESULT;
            default:             state_d = S_RESULT;
          endcase
        end
      end
      S_REDUCE: begin
        if (!acc_ge) begin
          state_d = (kind_q == lss_pkg::KIND_WRITE) ? S_RESULT : S_FETCH;
        end
      end
      S_TICK: begin
        if (tick_done) begin
          state_d = S_RESULT;
        end else if (!chan_skip) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        if (steps_max || off_end) begin
          state_d = fin_state;
          run_end = 1'b1;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (mem_rdata_i)
          lss_pkg::CMD_NOP, lss_pkg::CMD_ON, lss_pkg::CMD_OFF, lss_pkg::CMD_RESTART: begin
            state_d = S_FETCH;
          end
          lss_pkg::CMD_DELAY: begin
            if (off_end) begin
              state_d = fin_state;
              run_end = 1'b1;
            end else begin
              state_d = S_DELAY;
            end
          end
          default: begin
            state_d = fin_state;
            run_end = 1'b1;
          end
        endcase
      end
      S_DELAY: begin
        state_d = fin_state;
        run_end = 1'b1;
      end
      S_RESULT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      kind_q   <= lss_pkg::KIND_TICK;
      acc_q    <= '0;
      len_q    <= '0;
      data_q   <= '0;
      cur_ch_q <= '0;
      taken_q  <= 1'b0;
      err_q    <= '0;
      w_off_q  <= '0;
      w_addr_q <= '0;
      steps_q  <= '0;
      idle_q   <= '1;
      wait_q   <= '0;
      lit_q    <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        base_q[i]  <= '0;
        size_q[i]  <= '0;
        off_q[i]   <= '0;
        raddr_q[i] <= '0;
        ticks_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (run_end && (kind_q == lss_pkg::KIND_TICK)) begin
        cur_ch_q <= cur_ch_q + CW'(1);
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            kind_q   <= in_i.kind;
            acc_q    <= in_i.address;
            len_q    <= in_i.script_length;
            data_q   <= in_i.data_byte;
            cur_ch_q <= (in_i.kind == lss_pkg::KIND_TICK) ? '0 : CW'(chan4);
            taken_q  <= start_ok;
            err_q    <= '0;
          end
        end
        S_REDUCE: begin
          if (acc_ge) begin
            acc_q <= acc_q - 8'(SCRIPT_DEPTH);
          end else if (kind_q == lss_pkg::KIND_START) begin
            base_q[ci]  <= acc_red;
            size_q[ci]  <= len_sat;
            ticks_q[ci] <= '0;
            idle_q[ci]  <= 1'b0;
            wait_q[ci]  <= 1'b0;
            w_off_q     <= '0;
            w_addr_q    <= acc_red;
            steps_q     <= '0;
          end
        end
        S_TICK: begin
          if (!tick_done) begin
            if (idle_q[ci] || !wait_q[ci]) begin
              cur_ch_q <= cur_ch_q + CW'(1);
            end else if (ticks_q[ci] > 8'd1) begin
              ticks_q[ci] <= ticks_q[ci] - 8'd1;
              cur_ch_q    <= cur_ch_q + CW'(1);
            end else begin
              ticks_q[ci] <= '0;
              wait_q[ci]  <= 1'b0;
              w_off_q     <= off_q[ci];
              w_addr_q    <= raddr_q[ci];
              steps_q     <= '0;
            end
          end
        end
        S_FETCH: begin
          if (steps_max || off_end) begin
            idle_q[ci]  <= 1'b1;
            wait_q[ci]  <= 1'b0;
            ticks_q[ci] <= '0;
            if (steps_max) begin
              err_q[ci] <= 1'b1;
            end
          end else begin
            w_off_q  <= w_off_q + OW'(1);
            w_addr_q <= addr_inc;
          end
        end
        S_EXEC: begin
          unique case (mem_rdata_i)
            lss_pkg::CMD_NOP: begin
              steps_q <= steps_q + SW'(1);
            end
            lss_pkg::CMD_ON: begin
              lit_q[ci] <= 1'b1;
              steps_q   <= steps_q + SW'(1);
            end
            lss_pkg::CMD_OFF: begin
              lit_q[ci] <= 1'b0;
              steps_q   <= steps_q + SW'(1);
            end
            lss_pkg::CMD_RESTART: begin
              w_off_q  <= '0;
              w_addr_q <= base_q[ci];
              steps_q  <= steps_q + SW'(1);
            end
            lss_pkg::CMD_DELAY: begin
              if (off_end) begin
                idle_q[ci]  <= 1'b1;
                wait_q[ci]  <= 1'b0;
                ticks_q[ci] <= '0;
                err_q[ci]   <= 1'b1;
              end else begin
                w_off_q  <= w_off_q + OW'(1);
                w_addr_q <= addr_inc;
              end
            end
            lss_pkg::CMD_END: begin
              idle_q[ci]  <= 1'b1;
              wait_q[ci]  <= 1'b0;
              ticks_q[ci] <= '0;
            end
            default: begin
              idle_q[ci]  <= 1'b1;
              wait_q[ci]  <= 1'b0;
              ticks_q[ci] <= '0;
              err_q[ci]   <= 1'b1;
            end
          endcase
        end
        S_DELAY: begin
          // zero delay taken as one tick
          ticks_q[ci] <= (mem_rdata_i == 8'd0) ? 8'd1 : mem_rdata_i;
          off_q[ci]   <= w_off_q;
          raddr_q[ci] <= w_addr_q;
          wait_q[ci]  <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign in_i.ready   = state_q == S_IDLE;
  assign res_valid_o  = state_q == S_RESULT;

  always_comb begin
    res_o.led_on       = RES_W'(lit_q);
    res_o.channel_idle = RES_W'(idle_q);
    res_o.script_error = RES_W'(err_q);
    res_o.start_taken  = taken_q;
  end

  a_idle_not_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idle_q & wait_q) == '0)
    else $error("idle channel marked waiting");

  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= SW'(MAX_STEPS))
    else $error("step counter past limit");

  a_mem_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req_o.we && mem_req_o.re))
    else $error("script memory read and write together");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(res_o))
    else $error("result dropped or changed while stalled");

  a_ready_no_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !res_valid_o && !mem_req_o.re)
    else $error("item taken while previous still at work");

endmodule

// ===== rtl/core/led_script_sequencer.sv =====
`timescale 1ns / 1ps
// one item at a time; a write reduces its address modulo SCRIPT_DEPTH, then goes to the output register
// a start runs its script on the shared fetch/execute loop, with a delay state for a delay byte
// a tick visits each channel in turn and does one such run for each channel that is due
// the next item is taken once the result has moved to the output register
// async active-low reset: all channels idle, leds off, script memory left uncleared

module led_script_sequencer #(
  parameter int unsigned NUM_CHANNELS = lss_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned SCRIPT_DEPTH = lss_pkg::SCRIPT_DEPTH_DEF,
  parameter int unsigned MAX_STEPS    = lss_pkg::MAX_STEPS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lss_in_if.sink     in_i,
  lss_out_if.source  out_o
);

  lss_pkg::mem_req_t           mem_req;
  logic [lss_pkg::BYTE_W-1:0]  mem_rdata;
  logic                        res_valid;
  logic                        res_ready;
  lss_pkg::result_t            res;
  lss_pkg::result_t            out_q;
  logic                        out_valid_q;

  lss_script_mem #(
    .SCRIPT_DEPTH(SCRIPT_DEPTH)
  ) u_mem (
    .clk_i    (clk_i),
    .mem_req_i(mem_req),
    .rdata_o  (mem_rdata)
  );

  lss_seq #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .SCRIPT_DEPTH(SCRIPT_DEPTH),
    .MAX_STEPS   (MAX_STEPS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .mem_req_o  (mem_req),
    .mem_rdata_i(mem_rdata),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // output item register
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.led_on       = out_q.led_on;
  assign out_o.channel_idle = out_q.channel_idle;
  assign out_o.script_error = out_q.script_error;
  assign out_o.start_taken  = out_q.start_taken;

endmodule

// ===== tb/sv/lss_checker.sv =====
`timescale 1ns / 1ps

module lss_checker (
  input  logic clk_i,
  input  logic rst_ni,
  lss_in_if    in_mon,
  lss_out_if   out_mon,
  output int   errors_o,
  output int   pending_o
);
  import lss_pkg::*;

  localparam int unsigned NCH   = NUM_CHANNELS_DEF;
  localparam int unsigned DEPTH = SCRIPT_DEPTH_DEF;
  localparam int unsigned STEPS = MAX_STEPS_DEF;

  logic [BYTE_W-1:0] script_mem [DEPTH];
  logic [ADDR_W-1:0] ch_base    [NCH];
  logic [LEN_W-1:0]  ch_size    [NCH];
  logic [LEN_W-1:0]  ch_offset  [NCH];
  logic [7:0]        ch_ticks   [NCH];
  bit                ch_idle    [NCH];
  bit                ch_waiting [NCH];
  bit                ch_lit     [NCH];

  result_t expected_status [$];
  int      n_fail;

  function automatic logic [BYTE_W-1:0] fetch(int unsigned ch, int unsigned off);
    return script_mem[(ch_base[ch] + off) % DEPTH];
  endfunction

  function automatic void park(int unsigned ch);
    ch_idle[ch]    = 1'b1;
    ch_waiting[ch] = 1'b0;
    ch_ticks[ch]   = '0;
  endfunction

  // runs a channel up to its next delay or its end, returns 1 on a fault
  function automatic bit run_script(int unsigned ch);
    int unsigned       off;
    logic [BYTE_W-1:0] op;
    logic [BYTE_W-1:0] dly;
    off = ch_offset[ch];
    ch_waiting[ch] = 1'b0;
    for (int unsigned steps = 0; steps < STEPS; steps++) begin
      if (off >= ch_size[ch]) begin
        park(ch);
        return 1'b0;
      end
      op = fetch(ch, off);
      off++;
      case (op)
        CMD_NOP: ;
        CMD_ON:  ch_lit[ch] = 1'b1;
        CMD_OFF: ch_lit[ch] = 1'b0;
        CMD_DELAY: begin
          if (off >= ch_size[ch]) begin
            park(ch);
            return 1'b1;
          end
          dly = fetch(ch, off);
          off++;
          ch_ticks[ch]   = (dly == '0) ? 8'd1 : dly;
          ch_offset[ch]  = LEN_W'(off);
          ch_waiting[ch] = 1'b1;
          return 1'b0;
        end
        CMD_RESTART: off = 0;
        CMD_END: begin
          park(ch);
          return 1'b0;
        end
        default: begin
          park(ch);
          return 1'b1;
        end
      endcase
    end
    park(ch);
    return 1'b1;
  endfunction

  function automatic result_t predict_status(logic [KIND_W-1:0] kind, logic [CHAN_W-1:0] ch,
                                             logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len,
                                             logic [BYTE_W-1:0] data, logic imm);
    result_t st;
    st = '0;
    case (kind)
      KIND_TICK: begin
        for (int unsigned c = 0; c < NCH; c++) begin
          if (ch_idle[c] || !ch_waiting[c]) continue;
          if (ch_ticks[c] > 8'd1) begin
            ch_ticks[c]--;
            continue;
          end
          ch_ticks[c] = '0;
          if (run_script(c)) st.script_error[c] = 1'b1;
        end
      end
      KIND_WRITE: script_mem[addr % DEPTH] = data;
      KIND_START: begin
        if (ch < NCH && (imm || ch_idle[ch])) begin
          if (len > DEPTH) len = LEN_W'(DEPTH);
          ch_base[ch]    = addr;
          ch_size[ch]    = len;
          ch_offset[ch]  = '0;
          ch_ticks[ch]   = '0;
          ch_idle[ch]    = 1'b0;
          ch_waiting[ch] = 1'b0;
          st.start_taken = 1'b1;
          if (run_script(ch)) st.script_error[ch] = 1'b1;
        end
      end
      default: ;
    endcase
    for (int unsigned c = 0; c < NCH; c++) begin
      st.led_on[c]       = ch_lit[c];
      st.channel_idle[c] = ch_idle[c];
    end
    return st;
  endfunction

  function automatic void check_field(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endfunction

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      for (int c = 0; c < NCH; c++) begin
        ch_base[c]    = '0;
        ch_size[c]    = '0;
        ch_offset[c]  = '0;
        ch_ticks[c]   = '0;
        ch_idle[c]    = 1'b1;
        ch_waiting[c] = 1'b0;
        ch_lit[c]     = 1'b0;
      end
      expected_status.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.led_on       = out_mon.led_on;
        got.channel_idle = out_mon.channel_idle;
        got.script_error = out_mon.script_error;
        got.start_taken  = out_mon.start_taken;
        if (expected_status.size() == 0) begin
          $error("status item with none outstanding: %0h", got);
          n_fail++;
        end else begin
          want = expected_status.pop_front();
          check_field("led_on", want.led_on, got.led_on);
          check_field("channel_idle", want.channel_idle, got.channel_idle);
          check_field("script_error", want.script_error, got.script_error);
          check_field("start_taken", OUT_W'(want.start_taken), OUT_W'(got.start_taken));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_status.push_back(predict_status(in_mon.kind, in_mon.channel, in_mon.address,
                                                 in_mon.script_length, in_mon.data_byte,
                                                 in_mon.immediate));
      end
    end
    errors_o  <= n_fail;
    pending_o <= expected_status.size();
  end

endmodule

// ===== tb/sv/led_script_sequencer_test.sv =====
`timescale 1ns / 1ps

module led_script_sequencer_test;
  import lss_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam logic [CHAN_W-1:0] CHAN_BAD   = CHAN_W'(NUM_CHANNELS_DEF);
  localparam int unsigned       N_TARGET   = 1600;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAN_W-1:0] channel;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  script_length;
    logic [BYTE_W-1:0] data_byte;
    logic              immediate;
  } lss_item_t;

  logic        clk_i;
  logic        rst_ni;
  bit          steady;
  int unsigned n_items;
  int          err_count;
  int          n_pending;

  logic [BYTE_W-1:0] image [SCRIPT_DEPTH_DEF];

  lss_in_if  in_ch ();
  lss_out_if out_ch ();

  led_script_sequencer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  lss_checker i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .errors_o  (err_count),
    .pending_o (n_pending)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    out_ch.ready <= rst_ni && (steady || ($urandom_range(99) >= 28));
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic push(input lss_item_t it);
    if (!steady) begin
      while ($urandom_range(99) < 28) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= it.kind;
    in_ch.channel       <= it.channel;
    in_ch.address       <= it.address;
    in_ch.script_length <= it.script_length;
    in_ch.data_byte     <= it.data_byte;
    in_ch.immediate     <= it.immediate;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (it.kind != KIND_SPARE && !(it.kind == KIND_START && it.channel >= CHAN_BAD)) n_items++;
  endtask

  task automatic tick();
    lss_item_t it;
    it      = lss_item_t'({$urandom, $urandom});
    it.kind = KIND_TICK;
    push(it);
  endtask

  task automatic write_byte(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] data);
    lss_item_t it;
    it           = lss_item_t'({$urandom, $urandom});
    it.kind      = KIND_WRITE;
    it.address   = addr;
    it.data_byte = data;
    push(it);
  endtask

  task automatic start(input logic [CHAN_W-1:0] ch, input logic [ADDR_W-1:0] base,
                       input logic [LEN_W-1:0] len, input logic imm);
    lss_item_t it;
    it               = lss_item_t'({$urandom, $urandom});
    it.kind          = KIND_START;
    it.channel       = ch;
    it.address       = base;
    it.script_length = len;
    it.immediate     = imm;
    push(it);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (n_pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [CHAN_W-1:0] pick_channel();
    return ($urandom_range(99) < 92) ? CHAN_W'($urandom_range(NUM_CHANNELS_DEF - 1)) : CHAN_BAD;
  endfunction

  // a script of lamp and delay commands with random content, then a start on it
  task automatic random_script();
    logic [BYTE_W-1:0] body [$];
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  len;
    int unsigned       pick;
    base = ADDR_W'($urandom_range(255));
    repeat ($urandom_range(1, 8)) begin
      pick = $urandom_range(99);
      if (pick < 25) body.push_back(CMD_ON);
      else if (pick < 50) body.push_back(CMD_OFF);
      else if (pick < 60) body.push_back(CMD_NOP);
      else begin
        body.push_back(CMD_DELAY);
        pick = $urandom_range(99);
        if (pick < 60) body.push_back(BYTE_W'($urandom_range(3)));
        else if (pick < 85) body.push_back(BYTE_W'($urandom_range(4, 12)));
        else body.push_back(BYTE_W'($urandom_range(255)));
      end
    end
    pick = $urandom_range(99);
    if (pick < 45) body.push_back(CMD_END);
    else if (pick < 65) body.push_back(CMD_RESTART);
    foreach (body[k]) write_byte(ADDR_W'(base + k), body[k]);
    pick = $urandom_range(99);
    if (pick < 70) len = LEN_W'(body.size());
    else if (pick < 82) len = LEN_W'(body.size() - 1);
    else if (pick < 92) len = LEN_W'(body.size() + $urandom_range(8));
    else len = LEN_W'($urandom_range(256, 511));
    start(pick_channel(), base, len, 1'($urandom_range(1)));
  endtask

  initial begin
    int unsigned pick;
    int unsigned next_drain;
    lss_item_t   it;
    rst_ni              = 1'b0;
    steady              = 1'b0;
    n_items             = 0;
    in_ch.valid         <= 1'b0;
    in_ch.kind          <= KIND_TICK;
    in_ch.channel       <= '0;
    in_ch.address       <= '0;
    in_ch.script_length <= '0;
    in_ch.data_byte     <= '0;
    in_ch.immediate     <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the whole script memory so that no script reads an unwritten byte
    for (int a = 0; a < SCRIPT_DEPTH_DEF; a++) begin
      image[a] = ($urandom_range(99) < 75) ? BYTE_W'($urandom_range(CMD_END))
                                           : BYTE_W'($urandom_range(255));
    end
    image[8'h00] = CMD_ON;
    image[8'h01] = CMD_DELAY;
    image[8'h02] = 8'h00;
    image[8'h03] = CMD_OFF;
    image[8'h04] = CMD_DELAY;
    image[8'h05] = 8'h02;
    image[8'h06] = CMD_END;
    image[8'h08] = CMD_NOP;
    image[8'h09] = 8'hFF;
    image[8'h0C] = CMD_ON;
    image[8'h0D] = CMD_DELAY;
    image[8'h10] = CMD_NOP;
    image[8'h11] = CMD_RESTART;
    image[8'h14] = CMD_OFF;
    image[8'h15] = CMD_DELAY;
    image[8'h16] = 8'hFF;
    image[8'h17] = CMD_END;
    image[8'hFE] = CMD_ON;
    image[8'hFF] = CMD_DELAY;
    for (int a = 0; a < SCRIPT_DEPTH_DEF; a++) write_byte(ADDR_W'(a), image[a]);

    start(2'd0, 8'h00, 9'd7, 1'b0);
    start(2'd0, 8'h08, 9'd2, 1'b0);
    tick();
    start(2'd1, 8'h08, 9'd2, 1'b1);
    start(2'd2, 8'h0C, 9'd2, 1'b0);
    start(2'd1, 8'h10, 9'd2, 1'b1);
    start(2'd2, 8'h10, 9'h1FF, 1'b1);
    tick();
    tick();
    it = '1;
    push(it);
    start(CHAN_BAD, 8'h00, 9'd7, 1'b1);
    start(2'd0, 8'h14, 9'd4, 1'b0);
    tick();
    start(2'd0, 8'h00, 9'd3, 1'b1);
    tick();
    start(2'd1, 8'h00, 9'd0, 1'b0);
    start(2'd2, 8'hFE, 9'd4, 1'b0);
    tick();
    tick();
    tick();
    write_byte(8'h80, 8'h5A);
    drain();

    next_drain = n_items + 450;
    while (n_items < N_TARGET) begin
      steady = (n_items >= 900 && n_items < 1100);
      if (n_items >= next_drain) begin
        drain();
        next_drain = n_items + 450;
      end
      pick = $urandom_range(99);
      if (pick < 30) begin
        repeat ($urandom_range(1, 4)) tick();
      end else if (pick < 65) begin
        random_script();
      end else if (pick < 75) begin
        start(pick_channel(), ADDR_W'($urandom_range(255)), LEN_W'($urandom_range(511)),
              1'($urandom_range(1)));
      end else if (pick < 88) begin
        write_byte(ADDR_W'($urandom_range(255)), BYTE_W'($urandom_range(255)));
      end else if (pick < 92) begin
        it      = lss_item_t'({$urandom, $urandom});
        it.kind = KIND_SPARE;
        push(it);
      end else begin
        start(pick_channel(), ADDR_W'($urandom_range(255)), LEN_W'($urandom_range(4)),
              1'($urandom_range(1)));
      end
    end
    steady = 1'b0;

    drain();
    repeat (500) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
